// ===== rtl/core/lipsf_pkg.sv =====
// Shared constants, types and helper functions for the line framer.
// No dependencies; every other file of the block imports this package.
package lipsf_pkg;

  // Field widths
  localparam int TextW = 8;
  localparam int IdW   = 6;

  // Character and line codes
  localparam logic [IdW-1:0]   NoLine    = 6'd63;
  localparam logic [TextW-1:0] Newline   = 8'h0A;
  localparam logic [TextW-1:0] Space     = 8'h20;
  localparam logic [TextW-1:0] ShiftOut  = 8'h0E;
  localparam logic [TextW-1:0] ShiftIn   = 8'h0F;
  localparam logic [TextW-1:0] StripMask = 8'h7F;
  localparam logic [TextW-1:0] DigitBase = 8'h30;  // '0'
  localparam logic [TextW-1:0] AlphaBase = 8'h57;  // 'a' - 10
  localparam logic [IdW-1:0]   FirstAlpha = 6'd10;

  // Configuration register map
  localparam int CfgAddrW = 4;
  localparam int CfgIdxW  = 2;
  localparam logic [CfgIdxW-1:0] RegStandoutMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHighestId    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFallbackId   = 2'd2;

  localparam logic [IdW-1:0] HighestIdReset  = 6'd35;
  localparam logic [IdW-1:0] FallbackIdReset = 6'd1;

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  typedef struct packed {
    logic            standout_mode;
    logic [IdW-1:0]  highest_id;
    logic [IdW-1:0]  fallback_id;
  } cfg_t;

  // One classified word: which framing bytes precede the text byte
  typedef struct packed {
    logic              nl;       // close previous line first
    logic              pfx;      // id character and space
    logic [TextW-1:0]  id_chr;
    logic              sh;       // shift code present
    logic              sh_out;   // 1 = shift-out, 0 = shift-in
    logic [TextW-1:0]  chr;      // text byte after stripping
  } plan_t;

  function automatic logic [TextW-1:0] id_char(input logic [IdW-1:0] id);
    logic [TextW-1:0] wide_id;
    wide_id = {{(TextW-IdW){1'b0}}, id};
    if (id >= FirstAlpha) begin
      return AlphaBase + wide_id;
    end
    return DigitBase + wide_id;
  endfunction

endpackage

// ===== rtl/core/lipsf_in_if.sv =====
// Input channel: one text word with its line id and message start flag.
// Depends on lipsf_pkg.
interface lipsf_in_if;
  import lipsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [TextW-1:0]  text_byte;
  logic [IdW-1:0]    line_id;
  logic              message_start;

  modport source (output valid, text_byte, line_id, message_start, input ready);
  modport sink   (input valid, text_byte, line_id, message_start, output ready);
endinterface

// ===== rtl/core/lipsf_out_if.sv =====
// Output channel: one framed output word and its end-of-run flag.
// Depends on lipsf_pkg.
interface lipsf_out_if;
  import lipsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [TextW-1:0]  out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

// ===== rtl/core/lipsf_cfg.sv =====
// APB-style configuration registers: standout mode, highest id, fallback id.
// Depends on lipsf_pkg.
module lipsf_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lipsf_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output lipsf_pkg::cfg_t                cfg
);
  import lipsf_pkg::*;

  logic [CfgIdxW-1:0] idx;
  logic               wr;

  assign idx    = paddr[CfgAddrW-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.standout_mode <= 1'b0;
      cfg.highest_id    <= HighestIdReset;
      cfg.fallback_id   <= FallbackIdReset;
    end else if (wr) begin
      case (idx)
        RegStandoutMode: cfg.standout_mode <= pwdata[0];
        RegHighestId:    cfg.highest_id    <= pwdata[IdW-1:0];
        RegFallbackId:   cfg.fallback_id   <= pwdata[IdW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      RegStandoutMode: prdata = {31'd0, cfg.standout_mode};
      RegHighestId:    prdata = {{(32-IdW){1'b0}}, cfg.highest_id};
      RegFallbackId:   prdata = {{(32-IdW){1'b0}}, cfg.fallback_id};
      default:         prdata = 32'd0;
    endcase
  end
endmodule

// ===== rtl/core/lipsf_front.sv =====
// Front end: accepts text words, tracks line and standout state and
// classifies each word into a framing plan. Depends on lipsf_pkg, lipsf_in_if.
module lipsf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  lipsf_pkg::cfg_t       cfg,
  lipsf_in_if.sink              text_in,
  input  logic                  q_full,
  output logic                  q_push,
  output lipsf_pkg::plan_t      q_plan
);
  import lipsf_pkg::*;

  logic [IdW-1:0] open_line_id, open_line_id_next;
  logic           standout_active, standout_active_next;
  logic           accept;
  logic [IdW-1:0] eff_id;
  logic           sa_start;
  logic           nonzero;

  assign text_in.ready = ~q_full;
  assign accept        = text_in.valid & ~q_full;
  assign nonzero       = text_in.text_byte != '0;

  // Classification of the word against the current line state
  always_comb begin
    eff_id   = (text_in.line_id > cfg.highest_id) ? cfg.fallback_id : text_in.line_id;
    sa_start = text_in.message_start ? 1'b0 : standout_active;

    q_plan.nl     = (open_line_id != NoLine) && (open_line_id != eff_id);
    q_plan.pfx    = q_plan.nl || (open_line_id == NoLine);
    q_plan.id_chr = id_char(eff_id);
    q_plan.sh     = 1'b0;
    q_plan.sh_out = 1'b0;
    q_plan.chr    = text_in.text_byte;
    standout_active_next = sa_start;

    if (cfg.standout_mode) begin
      if (text_in.text_byte[TextW-1]) begin
        q_plan.sh            = ~sa_start;
        q_plan.sh_out        = 1'b1;
        q_plan.chr           = text_in.text_byte & StripMask;
        standout_active_next = 1'b1;
      end else if (sa_start) begin
        q_plan.sh            = 1'b1;
        standout_active_next = 1'b0;
      end
    end

    open_line_id_next = (q_plan.chr == Newline) ? NoLine : eff_id;
  end

  // A zero word only clears standout on message start
  assign q_push = accept & nonzero;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_line_id    <= NoLine;
      standout_active <= 1'b0;
    end else if (accept) begin
      if (nonzero) begin
        open_line_id    <= open_line_id_next;
        standout_active <= standout_active_next;
      end else begin
        standout_active <= sa_start;
      end
    end
  end
endmodule

// ===== rtl/core/lipsf_queue.sv =====
// Short register queue of framing plans between front and back.
// Depends on lipsf_pkg.
module lipsf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lipsf_pkg::plan_t      push_plan,
  output logic                  full,
  input  logic                  pop,
  output lipsf_pkg::plan_t      head,
  output logic                  empty
);
  import lipsf_pkg::*;

  plan_t            slots [QDepth];
  logic [QPtrW-1:0] wr_ptr, rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = count == QCntW'(QDepth);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_plan;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ===== rtl/core/lipsf_back.sv =====
// Back end: walks the head plan and, via an output register, sends one
// output word a cycle unless stalled. Depends on lipsf_pkg, lipsf_out_if.
module lipsf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  lipsf_pkg::plan_t      head,
  output logic                  q_pop,
  lipsf_out_if.source           frame_out
);
  import lipsf_pkg::*;

  // done bits: newline, id character, space, shift code
  logic [3:0]       done, done_next;
  logic [3:0]       pend;
  logic             advance;
  logic [TextW-1:0] sel_byte;
  logic             sel_last;
  logic             out_v;
  logic [TextW-1:0] out_byte;
  logic             out_last;

  assign advance = ~q_empty & (~out_v | frame_out.ready);
  assign pend    = {head.sh & ~done[3], head.pfx & ~done[2],
                    head.pfx & ~done[1], head.nl & ~done[0]};

  // Pick the first framing byte still owed, else the text byte
  always_comb begin
    sel_last  = 1'b0;
    done_next = done;
    if (pend[0]) begin
      sel_byte     = Newline;
      done_next[0] = 1'b1;
    end else if (pend[1]) begin
      sel_byte     = head.id_chr;
      done_next[1] = 1'b1;
    end else if (pend[2]) begin
      sel_byte     = Space;
      done_next[2] = 1'b1;
    end else if (pend[3]) begin
      sel_byte     = head.sh_out ? ShiftOut : ShiftIn;
      done_next[3] = 1'b1;
    end else begin
      sel_byte  = head.chr;
      sel_last  = 1'b1;
      done_next = '0;
    end
  end

  assign q_pop = advance & sel_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      done  <= '0;
    end else begin
      if (advance) begin
        out_v <= 1'b1;
        done  <= done_next;
      end else if (frame_out.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= sel_byte;
      out_last <= sel_last;
    end
  end

  assign frame_out.valid       = out_v;
  assign frame_out.out_byte    = out_byte;
  assign frame_out.last_of_run = out_last;
endmodule

// ===== rtl/core/line_id_prefix_standout_framer.sv =====
// Line framer with id prefix and standout shift codes; top level.
// Depends on lipsf_pkg, lipsf_in_if, lipsf_out_if and the lipsf_* modules.

// Each accepted text word yields one to five output words: a closing newline
// when the line id changes, the id character and a space at a line start, a
// shift code in standout mode when standout turns on or off, then the text
// byte, last_of_run marking the final one. The front end takes a word every
// cycle while its four-entry plan queue has room; the back end sends one
// output word per cycle while the output is ready, and that output stage sets
// the sustained rate. A zero text byte gives no output. Configuration is
// written over the APB port at byte addresses 0, 4 and 8 while the block is
// idle; the user must keep to this, as the block does not enforce it.
module line_id_prefix_standout_framer (
  input  logic                           clk,
  input  logic                           rst,
  lipsf_in_if.sink                       text_in,
  lipsf_out_if.source                    frame_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lipsf_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import lipsf_pkg::*;

  cfg_t  cfg;
  plan_t push_plan;
  plan_t head;
  logic  push, pop, full, empty;

  lipsf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lipsf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .text_in (text_in),
    .q_full  (full),
    .q_push  (push),
    .q_plan  (push_plan)
  );

  lipsf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_plan (push_plan),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  lipsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (empty),
    .head      (head),
    .q_pop     (pop),
    .frame_out (frame_out)
  );
endmodule
